>>> design/pneumatic_valve_pressure_controller_assert.svh
// ----------------------------------------------------------------------------
// Pneumatic valve pressure controller: assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PNEUMATIC_VALVE_PRESSURE_CONTROLLER_ASSERT_SVH
`define PNEUMATIC_VALVE_PRESSURE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define PVPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication
`define PVPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define PVPC_ASSERT_IMP(lbl, ante, cons)
`define PVPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/pvpc_pkg.sv
// ----------------------------------------------------------------------------
// pvpc_pkg
// Shared types, widths and reset values of the pressure controller.
// ----------------------------------------------------------------------------
package pvpc_pkg;

  // Field and datapath widths
  localparam int OP_W       = 16;
  localparam int PROD_W     = 2 * OP_W;
  localparam int TIME_W     = 32;
  localparam int INERTIA_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Serial unit step counts
  localparam int MUL_STEPS  = OP_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Constant divisor of the band unit and its remainder width
  localparam int DEC_DIVISOR = 10;
  localparam int DEC_REM_W   = $clog2(DEC_DIVISOR);

  // Register reset values
  localparam logic signed [OP_W-1:0]      LOW_PRESS_RST         = 16'sd0;
  localparam logic signed [OP_W-1:0]      MAX_PRESSURE_RST      = 16'sd32767;
  localparam logic signed [OP_W-1:0]      SAFETY_STOP_RST       = 16'sd32767;
  localparam logic        [INERTIA_W-1:0] DEFLATION_INERTIA_RST = 15'd500;
  localparam logic signed [OP_W-1:0]      MAP_MIN_RST           = 16'sd1000;
  localparam logic signed [OP_W-1:0]      MAP_MAX_RST           = 16'sd1510;
  localparam logic        [OP_W-1:0]      TIMEOUT_MS_RST        = 16'd10000;

  // Valve drive codes
  typedef enum logic [1:0] {
    VALVE_CLOSED  = 2'd0,
    VALVE_INFLATE = 2'd1,
    VALVE_DEFLATE = 2'd2
  } valve_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_PRESS         = 3'd0,
    CFG_MAX_PRESSURE      = 3'd1,
    CFG_SAFETY_STOP       = 3'd2,
    CFG_DEFLATION_INERTIA = 3'd3,
    CFG_MAP_MIN           = 3'd4,
    CFG_MAP_MAX           = 3'd5,
    CFG_TIMEOUT_MS        = 3'd6
  } cfg_idx_t;

  // Input beat
  typedef struct packed {
    logic signed [OP_W-1:0]   pressure;
    logic signed [OP_W-1:0]   setpoint;
    logic                     trigger;
    logic        [TIME_W-1:0] now_ms;
  } pvpc_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]             valve_drive;
    logic                   inflating;
    logic                   deflating;
    logic                   over_pressure;
    logic signed [OP_W-1:0] setpoint_raw;
  } pvpc_out_t;

endpackage

>>> design/pvpc_mul.sv
// ----------------------------------------------------------------------------
// pvpc_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pvpc_mul import pvpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OP_W-1:0]   mcand,
  input  logic [OP_W-1:0]   mplier,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [PROD_W-1:0] prod_r;
  logic [OP_W-1:0]   mcand_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [OP_W:0]     sum;

  // Add multiplicand into the upper half when the low bit is set
  always_comb begin
    sum = {1'b0, prod_r[PROD_W-1:OP_W]} + {1'b0, (prod_r[0] ? mcand_r : '0)};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift product right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{OP_W{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (run_r) begin
      prod_r <= {sum, prod_r[OP_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

>>> design/pvpc_div.sv
// ----------------------------------------------------------------------------
// pvpc_div
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvpc_div import pvpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [OP_W-1:0]   divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic [PROD_W-1:0] dq_r;
  logic [OP_W-1:0]   rem_r;
  logic [OP_W-1:0]   dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [OP_W:0]     shifted;
  logic [OP_W+1:0]   trial;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, dq_r[PROD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Keep remainder on a non-negative trial, shift quotient bit in
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!trial[OP_W+1]) begin
        rem_r <= trial[OP_W-1:0];
        dq_r  <= {dq_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[OP_W-1:0];
        dq_r  <= {dq_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> design/pvpc_div10.sv
// ----------------------------------------------------------------------------
// pvpc_div10
// Bit-serial division of a 16-bit magnitude by ten, one bit per cycle.
// ----------------------------------------------------------------------------
module pvpc_div10 import pvpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] dividend,
  output logic            done,
  output logic [OP_W-1:0] quotient
);

  logic [OP_W-1:0]      dq_r;
  logic [DEC_REM_W-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DEC_REM_W:0]   shifted;
  logic                 ge;

  // Compare shifted remainder against the constant
  always_comb begin
    shifted = {rem_r, dq_r[OP_W-1]};
    ge      = (shifted >= (DEC_REM_W+1)'(DEC_DIVISOR));
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(OP_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Subtract ten when it fits, shift quotient bit in
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= DEC_REM_W'(shifted - (DEC_REM_W+1)'(DEC_DIVISOR));
      end else begin
        rem_r <= shifted[DEC_REM_W-1:0];
      end
      dq_r <= {dq_r[OP_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> design/pneumatic_valve_pressure_controller.sv
// ----------------------------------------------------------------------------
// Pneumatic valve pressure controller
// Setpoint mapping, valve sequencing, timeouts, refill and over-pressure stop.
// ----------------------------------------------------------------------------
// One sample in, one result out. From acceptance to the result register, a
// sample passes these steps in order: a load step loads the operands, a
// 16-step serial multiplier forms the mapping product (the pressure band
// divide by ten runs alongside it), a hand-over step passes the product on,
// a 32-step serial divider scales it by the setpoint span, a hand-over step
// passes the quotient on, and three more steps map, compare and commit. The
// next sample is accepted in the cycle after the commit at the earliest, so
// a sample is taken only once the previous one is committed, even while the
// previous result still waits in the output register; the commit waits only
// if that register is still full and out_stall is high. Configuration writes
// are taken every cycle and must only be made while the controller is idle.
// ----------------------------------------------------------------------------
`include "pneumatic_valve_pressure_controller_assert.svh"

module pneumatic_valve_pressure_controller import pvpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pvpc_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output pvpc_out_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_MAP,
    ST_THR,
    ST_FIN
  } state_t;

  // Configuration registers
  logic signed [OP_W-1:0]      low_press_r;
  logic signed [OP_W-1:0]      max_pressure_r;
  logic signed [OP_W-1:0]      safety_stop_r;
  logic        [INERTIA_W-1:0] deflation_inertia_r;
  logic signed [OP_W-1:0]      map_min_r;
  logic signed [OP_W-1:0]      map_max_r;
  logic        [OP_W-1:0]      timeout_ms_r;

  // Sequencer and held beat
  state_t    state_r;
  pvpc_in_t  in_r;
  logic      out_valid_r;
  pvpc_out_t out_data_r;
  logic      commit;

  // Mapping bookkeeping
  logic                   sgn_q_r;
  logic                   den_zero_r;
  logic                   span_neg_r;
  logic [OP_W-1:0]        den_mag_r;
  logic signed [OP_W-1:0] sp_r;

  // Compare flags
  logic f_ne_r, f_lt_r, f_gt_r, f_stop_inf_r, f_stop_def_r, f_refill_r;
  logic f_to_inf_r, f_to_def_r, over_r;

  // Controller state
  valve_t                 valve_r;
  logic                   inf_r;
  logic                   def_r;
  logic signed [OP_W-1:0] last_sp_r;
  logic [TIME_W-1:0]      inf_start_r;
  logic [TIME_W-1:0]      def_start_r;

  // Next controller state
  valve_t                 valve_nxt;
  logic                   inf_nxt;
  logic                   def_nxt;
  logic signed [OP_W-1:0] last_sp_nxt;
  logic [TIME_W-1:0]      inf_start_nxt;
  logic [TIME_W-1:0]      def_start_nxt;
  logic                   took_inf;
  logic                   took_def;

  // Serial unit hookup
  logic              mul_start, mul_done;
  logic [PROD_W-1:0] product;
  logic              div_start, div_done;
  logic [PROD_W-1:0] quot;
  logic              d10_done;
  logic [OP_W-1:0]   q10;

  // Operand differences and magnitudes
  logic signed [OP_W:0]   a_diff, b_diff, den_diff, span_diff;
  logic [OP_W-1:0]        a_mag, b_mag, den_mag, span_mag;

  // Mapping sum and band thresholds
  logic signed [PROD_W:0]   q_sgn;
  logic signed [PROD_W+1:0] map_sum;
  logic signed [OP_W-1:0]   sp_map;
  logic signed [OP_W+1:0]   d10, d20, p18, sp18, thr10, thr20, thr_def;
  logic [TIME_W-1:0]        inf_elapsed, def_elapsed;

  function automatic logic [OP_W-1:0] mag17(input logic signed [OP_W:0] x);
    logic signed [OP_W:0] n;
    n = -x;
    return x[OP_W] ? n[OP_W-1:0] : x[OP_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_press_r         <= LOW_PRESS_RST;
      max_pressure_r      <= MAX_PRESSURE_RST;
      safety_stop_r       <= SAFETY_STOP_RST;
      deflation_inertia_r <= DEFLATION_INERTIA_RST;
      map_min_r           <= MAP_MIN_RST;
      map_max_r           <= MAP_MAX_RST;
      timeout_ms_r        <= TIMEOUT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOW_PRESS:         low_press_r         <= cfg_data;
        CFG_MAX_PRESSURE:      max_pressure_r      <= cfg_data;
        CFG_SAFETY_STOP:       safety_stop_r       <= cfg_data;
        CFG_DEFLATION_INERTIA: deflation_inertia_r <= cfg_data[INERTIA_W-1:0];
        CFG_MAP_MIN:           map_min_r           <= cfg_data;
        CFG_MAP_MAX:           map_max_r           <= cfg_data;
        CFG_TIMEOUT_MS:        timeout_ms_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Form signed differences for the mapping and the pressure band
  always_comb begin
    a_diff    = {in_r.setpoint[OP_W-1], in_r.setpoint} - {map_min_r[OP_W-1], map_min_r};
    b_diff    = {max_pressure_r[OP_W-1], max_pressure_r}
              - {low_press_r[OP_W-1], low_press_r};
    den_diff  = {map_max_r[OP_W-1], map_max_r} - {map_min_r[OP_W-1], map_min_r};
    span_diff = {in_r.pressure[OP_W-1], in_r.pressure}
              - {low_press_r[OP_W-1], low_press_r};
    a_mag     = mag17(a_diff);
    b_mag     = mag17(b_diff);
    den_mag   = mag17(den_diff);
    span_mag  = mag17(span_diff);
  end

  assign mul_start = (state_r == ST_PREP);
  assign div_start = (state_r == ST_MUL) && mul_done;

  pvpc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (a_mag),
    .mplier  (b_mag),
    .done    (mul_done),
    .product (product)
  );

  pvpc_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .dividend (span_mag),
    .done     (d10_done),
    .quotient (q10)
  );

  pvpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (den_mag_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Apply sign, offset by the lowest working pressure and saturate
  always_comb begin
    q_sgn   = sgn_q_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    map_sum = $signed({q_sgn[PROD_W], q_sgn})
            + $signed({{(PROD_W+2-OP_W){low_press_r[OP_W-1]}}, low_press_r});
    if (den_zero_r) begin
      sp_map = low_press_r;
    end else if (map_sum > (PROD_W+2)'(signed'(32767))) begin
      sp_map = 16'sh7fff;
    end else if (map_sum < -(PROD_W+2)'(signed'(32768))) begin
      sp_map = 16'sh8000;
    end else begin
      sp_map = map_sum[OP_W-1:0];
    end
  end

  // Build the pressure bands around the mapped setpoint
  always_comb begin
    d10         = span_neg_r ? -$signed({2'b00, q10}) : $signed({2'b00, q10});
    d20         = span_neg_r ? -$signed({3'b000, q10[OP_W-1:1]})
                             : $signed({3'b000, q10[OP_W-1:1]});
    p18         = {{2{in_r.pressure[OP_W-1]}}, in_r.pressure};
    sp18        = {{2{sp_r[OP_W-1]}}, sp_r};
    thr10       = sp18 - d10;
    thr20       = sp18 - d20;
    thr_def     = sp18 + $signed({3'b000, deflation_inertia_r});
    inf_elapsed = in_r.now_ms - inf_start_r;
    def_elapsed = in_r.now_ms - def_start_r;
  end

  // Hold mapping bookkeeping and compare flags
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      sgn_q_r    <= a_diff[OP_W] ^ b_diff[OP_W] ^ den_diff[OP_W];
      den_zero_r <= (den_diff == '0);
      span_neg_r <= span_diff[OP_W];
      den_mag_r  <= den_mag;
    end
    if (state_r == ST_MAP) begin
      sp_r <= sp_map;
    end
    if (state_r == ST_THR) begin
      f_ne_r       <= (sp_r != last_sp_r);
      f_lt_r       <= (in_r.pressure < sp_r);
      f_gt_r       <= (in_r.pressure > sp_r);
      f_stop_inf_r <= (p18 > thr20);
      f_stop_def_r <= (p18 < thr_def);
      f_refill_r   <= (p18 < thr10);
      f_to_inf_r   <= (inf_elapsed > {{(TIME_W-OP_W){1'b0}}, timeout_ms_r});
      f_to_def_r   <= (def_elapsed > {{(TIME_W-OP_W){1'b0}}, timeout_ms_r});
      over_r       <= (in_r.pressure > safety_stop_r);
    end
  end

  // Decide valves: over-pressure, command chain, timeouts, refill
  always_comb begin
    valve_nxt     = valve_r;
    inf_nxt       = inf_r;
    def_nxt       = def_r;
    last_sp_nxt   = last_sp_r;
    inf_start_nxt = inf_start_r;
    def_start_nxt = def_start_r;
    took_inf      = 1'b0;
    took_def      = 1'b0;
    if (over_r) begin
      valve_nxt = VALVE_CLOSED;
    end
    priority if (f_ne_r && f_lt_r && in_r.trigger) begin
      def_nxt       = 1'b0;
      valve_nxt     = VALVE_INFLATE;
      inf_nxt       = 1'b1;
      inf_start_nxt = in_r.now_ms;
      last_sp_nxt   = sp_r;
      took_inf      = 1'b1;
    end else if (inf_r && f_stop_inf_r) begin
      valve_nxt = VALVE_CLOSED;
      inf_nxt   = 1'b0;
    end else if (f_ne_r && f_gt_r && in_r.trigger) begin
      inf_nxt       = 1'b0;
      valve_nxt     = VALVE_DEFLATE;
      def_nxt       = 1'b1;
      def_start_nxt = in_r.now_ms;
      last_sp_nxt   = sp_r;
      took_def      = 1'b1;
    end else if (def_r && f_stop_def_r) begin
      valve_nxt = VALVE_CLOSED;
      def_nxt   = 1'b0;
    end else begin
      took_inf = 1'b0;
    end
    // a move started in this step has zero elapsed time
    if (inf_nxt && !took_inf && f_to_inf_r) begin
      inf_nxt   = 1'b0;
      valve_nxt = VALVE_CLOSED;
    end
    if (def_nxt && !took_def && f_to_def_r) begin
      def_nxt   = 1'b0;
      valve_nxt = VALVE_CLOSED;
    end
    if (!inf_nxt && !def_nxt && f_refill_r && !in_r.trigger) begin
      valve_nxt     = VALVE_INFLATE;
      inf_nxt       = 1'b1;
      inf_start_nxt = in_r.now_ms;
    end
  end

  // Update controller state on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_r     <= VALVE_CLOSED;
      inf_r       <= 1'b0;
      def_r       <= 1'b0;
      last_sp_r   <= '0;
      inf_start_r <= '0;
      def_start_r <= '0;
    end else if (commit) begin
      valve_r     <= valve_nxt;
      inf_r       <= inf_nxt;
      def_r       <= def_nxt;
      last_sp_r   <= last_sp_nxt;
      inf_start_r <= inf_start_nxt;
      def_start_r <= def_start_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Sequence one beat and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r              <= 1'b1;
        out_data_r.valve_drive   <= valve_nxt;
        out_data_r.inflating     <= inf_nxt;
        out_data_r.deflating     <= def_nxt;
        out_data_r.over_pressure <= over_r;
        out_data_r.setpoint_raw  <= sp_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_PREP;
        ST_PREP: state_r <= ST_MUL;
        ST_MUL:  if (mul_done) state_r <= ST_DIV;
        ST_DIV:  if (div_done) state_r <= ST_MAP;
        ST_MAP:  state_r <= ST_THR;
        ST_THR:  state_r <= ST_FIN;
        ST_FIN:  if (commit) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `PVPC_ASSERT_IMP(a_units_align, mul_done, d10_done)
  `PVPC_ASSERT_IMP(a_one_move, 1'b1, !(inf_r && def_r))
  `PVPC_ASSERT_IMP(a_inflate_flag, valve_r == VALVE_INFLATE, inf_r)
  `PVPC_ASSERT_IMP(a_deflate_flag, valve_r == VALVE_DEFLATE, def_r)
  `PVPC_ASSERT_NXT(a_accept_prep, in_valid && !in_stall, state_r == ST_PREP)

endmodule
